@@ design/pwsv_pkg.sv @@
// ============================================================================
// pwsv_pkg: shared types and constants for the pulse waveform source
// Time and level widths, configuration register indexes and queue types.
// ============================================================================
`default_nettype none
package pwsv_pkg;
    localparam int TimeWidth  = 32;
    localparam int LevelWidth = 16;
    localparam int CountWidth = 16;
    localparam int LimitWidth = TimeWidth + CountWidth;
    localparam int MagWidth   = LevelWidth + 1;
    localparam int ProdWidth  = MagWidth + TimeWidth;
    localparam int CfgIdxWidth = 3;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_LOW    = 3'd0,
        CFG_HIGH   = 3'd1,
        CFG_DELAY  = 3'd2,
        CFG_RISE   = 3'd3,
        CFG_FALL   = 3'd4,
        CFG_ON     = 3'd5,
        CFG_PERIOD = 3'd6,
        CFG_CYCLES = 3'd7
    } cfg_idx_t;

    // Segment of the period that a sample falls into.
    typedef enum logic [1:0] {
        SEG_LOW  = 2'd0,
        SEG_RISE = 2'd1,
        SEG_HIGH = 2'd2,
        SEG_FALL = 2'd3
    } seg_t;

    typedef struct packed {
        logic signed [LevelWidth-1:0] low_level;
        logic signed [LevelWidth-1:0] high_level;
        logic [TimeWidth-1:0]         delay_time;
        logic [TimeWidth-1:0]         rise_time;
        logic [TimeWidth-1:0]         fall_time;
        logic [TimeWidth-1:0]         on_time;
        logic [TimeWidth-1:0]         period_time;
        logic [CountWidth-1:0]        cycle_count;
    } cfg_t;

    // Item as classified by the front end: elapsed time already clamped.
    typedef struct packed {
        logic                 active;
        logic [LimitWidth-1:0] elapsed;
        logic [TimeWidth-1:0] step_time;
    } front_item_t;
endpackage
`default_nettype wire

@@ design/pwsv_front.sv @@
// ============================================================================
// pwsv_front: input stage
// Accept items, subtract the delay and clamp to the end of the pulse train.
// ============================================================================
`default_nettype none
module pwsv_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pwsv_pkg::cfg_t                 cfg,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [pwsv_pkg::TimeWidth-1:0] sample_time,
    input  wire logic [pwsv_pkg::TimeWidth-1:0] step_time,
    output logic                                fr_valid,
    input  wire logic                           fr_stall,
    output pwsv_pkg::front_item_t               fr_item
);
    import pwsv_pkg::*;

    // Stage 1: elapsed time and train length.
    logic                  s1_valid_reg;
    logic                  s1_active_reg;
    logic [TimeWidth-1:0]  s1_elapsed_reg;
    logic [LimitWidth-1:0] s1_limit_reg;
    logic [TimeWidth-1:0]  s1_step_reg;
    logic                  s2_valid_reg;
    front_item_t           s2_item_reg;
    logic                  adv1;
    logic                  adv2;
    logic [LimitWidth-1:0] elapsed_wide;

    assign adv2     = !s2_valid_reg || !fr_stall;
    assign adv1     = !s1_valid_reg || adv2;
    assign in_stall = !adv1;
    assign fr_valid = s2_valid_reg;
    assign fr_item  = s2_item_reg;
    assign elapsed_wide = {{CountWidth{1'b0}}, s1_elapsed_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                s1_valid_reg <= in_valid;
            if (adv2)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_active_reg  <= (sample_time >= cfg.delay_time);
            s1_elapsed_reg <= sample_time - cfg.delay_time;
            s1_limit_reg   <= LimitWidth'(cfg.period_time * cfg.cycle_count);
            s1_step_reg    <= step_time;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_item_reg.active    <= s1_active_reg;
            s2_item_reg.elapsed   <= (elapsed_wide > s1_limit_reg) ? s1_limit_reg
                                                                   : elapsed_wide;
            s2_item_reg.step_time <= s1_step_reg;
        end
    end
endmodule
`default_nettype wire

@@ design/pwsv_queue.sv @@
// ============================================================================
// pwsv_queue: two-entry queue between front and back
// Decouple the stall of the back end from the front end.
// ============================================================================
`default_nettype none
module pwsv_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_valid,
    output logic                       wr_stall,
    input  wire pwsv_pkg::front_item_t wr_item,
    output logic                       rd_valid,
    input  wire logic                  rd_stall,
    output pwsv_pkg::front_item_t      rd_item
);
    import pwsv_pkg::*;

    front_item_t mem_reg [2];
    logic        wp_reg;
    logic        rp_reg;
    logic [1:0]  cnt_reg;
    logic        do_wr;
    logic        do_rd;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && !wr_stall;
    assign do_rd    = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= !wp_reg;
            if (do_rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(do_wr) - 2'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_item;
    end
endmodule
`default_nettype wire

@@ design/pwsv_back.sv @@
// ============================================================================
// pwsv_back: evaluation pipeline
// Phase by restoring division, segment select, ramp multiply and divide.
// ============================================================================
`default_nettype none
module pwsv_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire pwsv_pkg::cfg_t                  cfg,
    input  wire logic                            bk_valid,
    output logic                                 bk_stall,
    input  wire pwsv_pkg::front_item_t           bk_item,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [pwsv_pkg::LevelWidth-1:0]      source_value
);
    import pwsv_pkg::*;

    // Phase stages: one quotient bit of elapsed / period per stage.
    localparam int PhStages = LimitWidth;
    // Ramp divide stages: one quotient bit per stage.
    localparam int DvStages = ProdWidth;
    localparam int NStages  = PhStages + 2 + DvStages + 1;
    localparam int RemWidth = TimeWidth + 1;

    typedef struct packed {
        logic                  active;
        logic [LimitWidth-1:0] num;
        logic [RemWidth-1:0]   rem;
        logic [TimeWidth-1:0]  step_time;
    } ph_t;

    typedef struct packed {
        logic                  neg;
        logic                  ramp;
        logic signed [LevelWidth-1:0] base;
        logic [ProdWidth-1:0]  num;
        logic [RemWidth-1:0]   rem;
        logic [ProdWidth-1:0]  quo;
        logic [TimeWidth-1:0]  den;
    } dv_t;

    logic                  v_reg [NStages];
    logic                  adv   [NStages];
    ph_t                   ph_reg [PhStages];
    ph_t                   ph_next [PhStages];
    // Segment stage registers.
    logic                  sg_active_reg;
    seg_t                  sg_seg_reg;
    logic [TimeWidth-1:0]  sg_off_reg;
    logic [TimeWidth-1:0]  sg_len_reg;
    dv_t                   dv_reg [DvStages + 1];
    dv_t                   dv_next [DvStages];
    logic signed [LevelWidth-1:0] res_reg;

    // Combinational helpers for segment and multiply stages.
    logic [TimeWidth-1:0]  phase;
    logic [TimeWidth-1:0]  rise_len;
    logic [TimeWidth-1:0]  fall_len;
    logic [TimeWidth+1:0]  up_end;
    logic [TimeWidth+1:0]  fall_end;
    logic [TimeWidth+1:0]  phase_w;
    seg_t                  seg_next;
    logic [TimeWidth-1:0]  off_next;
    logic [TimeWidth-1:0]  len_next;
    logic signed [MagWidth-1:0] diff;
    logic [MagWidth-1:0]   mag;
    logic signed [LevelWidth-1:0] lo_lvl;
    logic signed [LevelWidth-1:0] hi_lvl;
    logic signed [MagWidth-1:0]   final_wide;

    assign lo_lvl = cfg.low_level;
    assign hi_lvl = cfg.high_level;

    // Stall chain: every stage advances unless the one after is full and held.
    always_comb
    begin
        adv[NStages-1] = !v_reg[NStages-1] || !out_stall;
        for (int i = NStages - 2; i >= 0; i--)
            adv[i] = !v_reg[i] || adv[i+1];
    end

    assign bk_stall     = !adv[0];
    assign out_valid    = v_reg[NStages-1];
    assign source_value = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NStages; i++)
                v_reg[i] <= 1'b0;
        end
        else
        begin
            if (adv[0])
                v_reg[0] <= bk_valid;
            for (int i = 1; i < NStages; i++)
                if (adv[i])
                    v_reg[i] <= v_reg[i-1];
        end
    end

    // Restoring division step for the phase.
    always_comb
    begin
        for (int i = 0; i < PhStages; i++)
        begin
            ph_t src;
            logic [RemWidth-1:0] r;
            if (i == 0)
            begin
                src.active    = bk_item.active;
                src.num       = bk_item.elapsed;
                src.rem       = '0;
                src.step_time = bk_item.step_time;
            end
            else
                src = ph_reg[i-1];
            r = {src.rem[RemWidth-2:0], src.num[LimitWidth-1]};
            if (r >= {1'b0, cfg.period_time})
                r = r - {1'b0, cfg.period_time};
            ph_next[i].active    = src.active;
            ph_next[i].num       = {src.num[LimitWidth-2:0], 1'b0};
            ph_next[i].rem       = r;
            ph_next[i].step_time = src.step_time;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PhStages; i++)
            if (adv[i])
                ph_reg[i] <= ph_next[i];
    end

    // Segment classification.
    always_comb
    begin
        phase    = (cfg.period_time == '0) ? '0
                                           : ph_reg[PhStages-1].rem[TimeWidth-1:0];
        rise_len = (cfg.rise_time == '0) ? ph_reg[PhStages-1].step_time : cfg.rise_time;
        fall_len = (cfg.fall_time == '0) ? ph_reg[PhStages-1].step_time : cfg.fall_time;
        up_end   = {2'b00, rise_len} + {2'b00, cfg.on_time};
        fall_end = up_end + {2'b00, fall_len};
        phase_w  = {2'b00, phase};
        off_next = phase;
        len_next = rise_len;
        if (phase < rise_len)
            seg_next = SEG_RISE;
        else if (phase_w < up_end)
            seg_next = SEG_HIGH;
        else if (phase_w < fall_end)
        begin
            seg_next = SEG_FALL;
            off_next = TimeWidth'(phase_w - up_end);
            len_next = fall_len;
        end
        else
            seg_next = SEG_LOW;
    end

    always_ff @(posedge clk)
    begin
        if (adv[PhStages])
        begin
            sg_active_reg <= ph_reg[PhStages-1].active;
            sg_seg_reg    <= seg_next;
            sg_off_reg    <= off_next;
            sg_len_reg    <= len_next;
        end
    end

    // Multiply level difference by offset.
    always_comb
    begin
        if (sg_seg_reg == SEG_FALL)
            diff = MagWidth'(lo_lvl) - MagWidth'(hi_lvl);
        else
            diff = MagWidth'(hi_lvl) - MagWidth'(lo_lvl);
        mag = diff[MagWidth-1] ? MagWidth'(-diff) : MagWidth'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (adv[PhStages+1])
        begin
            dv_reg[0].neg  <= diff[MagWidth-1];
            dv_reg[0].ramp <= sg_active_reg
                              && (sg_seg_reg == SEG_RISE || sg_seg_reg == SEG_FALL);
            if (!sg_active_reg || sg_seg_reg == SEG_LOW || sg_seg_reg == SEG_RISE)
                dv_reg[0].base <= lo_lvl;
            else
                dv_reg[0].base <= hi_lvl;
            dv_reg[0].num  <= ProdWidth'(mag * sg_off_reg);
            dv_reg[0].rem  <= '0;
            dv_reg[0].quo  <= '0;
            dv_reg[0].den  <= sg_len_reg;
        end
    end

    // Restoring division of the product by the edge length.
    always_comb
    begin
        for (int i = 0; i < DvStages; i++)
        begin
            logic [RemWidth-1:0] r;
            logic                q;
            r = {dv_reg[i].rem[RemWidth-2:0], dv_reg[i].num[ProdWidth-1]};
            q = (r >= {1'b0, dv_reg[i].den});
            if (q)
                r = r - {1'b0, dv_reg[i].den};
            dv_next[i]     = dv_reg[i];
            dv_next[i].num = {dv_reg[i].num[ProdWidth-2:0], 1'b0};
            dv_next[i].rem = r;
            dv_next[i].quo = {dv_reg[i].quo[ProdWidth-2:0], q};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DvStages; i++)
            if (adv[PhStages+2+i])
                dv_reg[i+1] <= dv_next[i];
    end

    // Apply the ramp quotient; it never leaves the level range.
    always_comb
    begin
        final_wide = MagWidth'(dv_reg[DvStages].base);
        if (dv_reg[DvStages].ramp)
        begin
            if (dv_reg[DvStages].neg)
                final_wide = final_wide - MagWidth'(dv_reg[DvStages].quo);
            else
                final_wide = final_wide + MagWidth'(dv_reg[DvStages].quo);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[NStages-1])
            res_reg <= final_wide[LevelWidth-1:0];
    end
endmodule
`default_nettype wire

@@ design/pulse_waveform_source_value_core.sv @@
// Stages: 2 front stages, the queue register, 48 phase
//   division stages, 1 segment stage, 1 multiply stage, 49 ramp division stages, 1 output.
// Throughput: one item per cycle while out_stall is low; each division stage resolves one quotient bit.
// Reset (rst_n, asynchronous low) clears all valid flags and loads the register
//   defaults: levels 0, times 0, period 1, cycle count 1.
// ============================================================================
// pulse_waveform_source_value_core: trapezoidal pulse source
// Returns the level of a periodic trapezoidal waveform at each sample time.
// ============================================================================
`default_nettype none
module pulse_waveform_source_value_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    // Configuration write channel.
    input  wire logic                                    cfg_valid,
    output logic                                         cfg_ready,
    input  wire logic [pwsv_pkg::CfgIdxWidth-1:0]        cfg_index,
    input  wire logic [pwsv_pkg::TimeWidth-1:0]          cfg_data,
    // Sample channel.
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic [pwsv_pkg::TimeWidth-1:0]          sample_time,
    input  wire logic [pwsv_pkg::TimeWidth-1:0]          step_time,
    // Result channel.
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed [pwsv_pkg::LevelWidth-1:0]       source_value
);
    import pwsv_pkg::*;

    cfg_t        cfg_reg;
    logic        fr_valid;
    logic        fr_stall;
    front_item_t fr_item;
    logic        bk_valid;
    logic        bk_stall;
    front_item_t bk_item;
    logic [LevelWidth-1:0] value_bits;

    // Registers are always writable; the user must make writes only while idle, as the block has no check for it.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_level   <= '0;
            cfg_reg.high_level  <= '0;
            cfg_reg.delay_time  <= '0;
            cfg_reg.rise_time   <= '0;
            cfg_reg.fall_time   <= '0;
            cfg_reg.on_time     <= '0;
            cfg_reg.period_time <= TimeWidth'(1);
            cfg_reg.cycle_count <= CountWidth'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LOW:    cfg_reg.low_level   <= cfg_data[LevelWidth-1:0];
                CFG_HIGH:   cfg_reg.high_level  <= cfg_data[LevelWidth-1:0];
                CFG_DELAY:  cfg_reg.delay_time  <= cfg_data;
                CFG_RISE:   cfg_reg.rise_time   <= cfg_data;
                CFG_FALL:   cfg_reg.fall_time   <= cfg_data;
                CFG_ON:     cfg_reg.on_time     <= cfg_data;
                CFG_PERIOD: cfg_reg.period_time <= cfg_data;
                CFG_CYCLES: cfg_reg.cycle_count <= cfg_data[CountWidth-1:0];
                default:    ;
            endcase
        end
    end

    // Front: delay subtract and clamp.
    pwsv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample_time (sample_time),
        .step_time   (step_time),
        .fr_valid    (fr_valid),
        .fr_stall    (fr_stall),
        .fr_item     (fr_item)
    );

    // Hold classified items while the back end stalls.
    pwsv_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_stall (fr_stall),
        .wr_item  (fr_item),
        .rd_valid (bk_valid),
        .rd_stall (bk_stall),
        .rd_item  (bk_item)
    );

    // Back: phase, segment, ramp arithmetic.
    pwsv_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .bk_valid     (bk_valid),
        .bk_stall     (bk_stall),
        .bk_item      (bk_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .source_value (value_bits)
    );

    assign source_value = value_bits;
endmodule
`default_nettype wire

@@ design/pwsv_checker.sv @@
// ============================================================================
// pwsv_checker: port-level checks for the pulse source
// Watch handshakes and configuration behavior at the top level ports.
// ============================================================================
`default_nettype none
module pwsv_checker (
    input wire logic                                 clk,
    input wire logic                                 rst_n,
    input wire logic                                 cfg_ready,
    input wire logic                                 in_stall,
    input wire logic                                 out_valid,
    input wire logic                                 out_stall,
    input wire logic [pwsv_pkg::LevelWidth-1:0]      source_value
);
    import pwsv_pkg::*;

    // Held result must not change.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(source_value))
        else $error("result changed while stalled");

    // No result can appear right after reset.
    a_no_early: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result right after reset");

    // Config port never stalls.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config port not ready");

    // Input stays open while the output drains freely.
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall && $past(!out_stall) && $past(!out_stall, 2) && $past(rst_n, 2)
        |-> !in_stall)
        else $error("input stalled with free output");
endmodule

bind pulse_waveform_source_value_core pwsv_checker u_pwsv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_ready    (cfg_ready),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .source_value (source_value)
);
`default_nettype wire

@@ dv/testbench.sv @@
// ============================================================================
// testbench: trapezoidal pulse source checker
// Drives sample transfers with random bursts, gaps and output stalls, predicts
// each waveform level from the register settings and compares results in order.
// ============================================================================
`default_nettype none

// Tracks expected waveform levels in transfer order.
class level_scoreboard;
    logic signed [15:0] pending_levels[$];
    int                 mismatches;

    function void note_sample(logic signed [15:0] level);
        pending_levels.push_back(level);
    endfunction

    // Print one line per mismatch and count it.
    task report(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task check_level(logic signed [15:0] got);
        logic signed [15:0] want;
        if (pending_levels.size() == 0)
            report($sformatf("source_value %0d with no level pending", got));
        else
        begin
            want = pending_levels.pop_front();
            if (got !== want)
                report($sformatf("source_value %0d, predicted %0d", got, want));
        end
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import pwsv_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CfgIdxWidth-1:0] cfg_index = '0;
    logic [TimeWidth-1:0]  cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [TimeWidth-1:0]  sample_time = '0;
    logic [TimeWidth-1:0]  step_time = 1;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic signed [LevelWidth-1:0] source_value;

    // Local copy of the register file.
    cfg_t            regs;
    level_scoreboard levels = new();
    bit              hold_off_on = 1'b0;
    bit              stall_random = 1'b1;
    int              hold_cycles = 0;

    // Drain margin covers the full pipeline depth.
    localparam int DrainCycles = 300;

    always #5 clk = ~clk;

    pulse_waveform_source_value_core dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample_time(sample_time), .step_time(step_time),
        .out_valid(out_valid), .out_stall(out_stall),
        .source_value(source_value)
    );

    // Ramp from start to stop: start + (stop-start)*off/len, truncated to zero.
    function automatic logic signed [63:0] ramp_level(logic signed [63:0] start,
            logic signed [63:0] stop, logic [63:0] off, logic [63:0] len);
        logic signed [63:0] diff;
        logic [127:0]       prod;
        logic [63:0]        mag;
        logic [63:0]        quo;
        diff = stop - start;
        mag  = (diff < 0) ? -diff : diff;
        prod = {64'd0, mag} * {64'd0, off};
        quo  = 64'(prod / {64'd0, len});
        return (diff < 0) ? start - $signed(quo) : start + $signed(quo);
    endfunction

    // Waveform level at sample time t for the current register settings.
    function automatic logic signed [15:0] waveform_level(logic [31:0] t,
            logic [31:0] stp);
        logic signed [63:0] lo, hi, val;
        logic [63:0] elapsed, limit, phase, rise, fall, up_end, fall_end;
        lo  = regs.low_level;
        hi  = regs.high_level;
        val = lo;
        if (t >= regs.delay_time)
        begin
            elapsed = t - regs.delay_time;
            limit   = 64'(regs.period_time) * 64'(regs.cycle_count);
            if (elapsed > limit)
                elapsed = limit;
            phase    = (regs.period_time != 0) ? elapsed % regs.period_time : 0;
            rise     = (regs.rise_time == 0) ? stp : regs.rise_time;
            fall     = (regs.fall_time == 0) ? stp : regs.fall_time;
            up_end   = rise + regs.on_time;
            fall_end = up_end + fall;
            if (phase < rise)
                val = ramp_level(lo, hi, phase, rise);
            else if (phase < up_end)
                val = hi;
            else if (phase < fall_end)
                val = ramp_level(hi, lo, phase - up_end, fall);
            else
                val = lo;
        end
        return val[15:0];
    endfunction

    // Write one register; only called while the pipeline is empty.
    task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_LOW:    regs.low_level   = data[15:0];
            CFG_HIGH:   regs.high_level  = data[15:0];
            CFG_DELAY:  regs.delay_time  = data;
            CFG_RISE:   regs.rise_time   = data;
            CFG_FALL:   regs.fall_time   = data;
            CFG_ON:     regs.on_time     = data;
            CFG_PERIOD: regs.period_time = data;
            CFG_CYCLES: regs.cycle_count = data[15:0];
        endcase
        @(negedge clk);
    endtask

    task automatic load_regs(logic [15:0] lo, logic [15:0] hi, logic [31:0] dly,
            logic [31:0] rise, logic [31:0] fall, logic [31:0] on_t,
            logic [31:0] per, logic [15:0] cyc);
        write_reg(CFG_LOW, {16'd0, lo});
        write_reg(CFG_HIGH, {16'd0, hi});
        write_reg(CFG_DELAY, dly);
        write_reg(CFG_RISE, rise);
        write_reg(CFG_FALL, fall);
        write_reg(CFG_ON, on_t);
        write_reg(CFG_PERIOD, per);
        write_reg(CFG_CYCLES, {16'd0, cyc});
        cfg_valid <= 1'b0;
    endtask

    // Offer one sample and hold it until the transfer happens.
    task automatic send_sample(logic [31:0] t, logic [31:0] stp);
        sample_time <= t;
        step_time   <= stp;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        levels.note_sample(waveform_level(t, stp));
        @(negedge clk);
    endtask

    // Random gap after a burst; lower valid only when a gap is taken.
    task automatic maybe_gap(ref int burst_left);
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every predicted level has arrived.
    task automatic drain();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (levels.pending_levels.size() != 0 && guard < 100000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Random sample time: mostly near the waveform, sometimes anywhere.
    function automatic logic [31:0] pick_time();
        logic [63:0] span;
        if ($urandom_range(0, 4) == 0)
            return $urandom();
        span = 64'(regs.delay_time) + 64'(regs.period_time)
            * (64'(regs.cycle_count) + 1) + 8;
        if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
        return 32'($urandom_range(0, 32'(span)));
    endfunction

    function automatic logic [31:0] pick_step();
        case ($urandom_range(0, 3))
            0: return 1;
            1: return $urandom();
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Receiver: random stall pattern, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (hold_off_on && hold_cycles < 400)
        begin
            out_stall   <= 1'b1;
            hold_cycles <= hold_cycles + 1;
        end
        else if (stall_random)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    // Check each result transfer at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            levels.check_level(source_value);
    end

    initial
    begin
        #20ms;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int burst_left;
        int phase_idx;
        int n;
        regs.low_level   = 0;
        regs.high_level  = 0;
        regs.delay_time  = 0;
        regs.rise_time   = 0;
        regs.fall_time   = 0;
        regs.on_time     = 0;
        regs.period_time = 1;
        regs.cycle_count = 1;
        burst_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset defaults first.
        send_sample(0, 1);
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Directed: extreme levels, zero edges use step, freeze at end.
        load_regs(16'h8000, 16'h7FFF, 10, 0, 0, 5, 40, 2);
        send_sample(9, 7);                 // before the delay
        send_sample(10, 7);                // start of rise
        send_sample(13, 7);                // mid rise, step edge
        send_sample(18, 7);                // high hold
        send_sample(24, 7);                // falling
        send_sample(35, 7);                // resting low
        send_sample(90, 7);                // past the end, frozen
        send_sample(32'hFFFF_FFFF, 1);
        drain();
        // Zero period, zero cycles, zero edge times that fall back to the step.
        load_regs(16'h7FFF, 16'h8000, 0, 0, 0, 0, 0, 0);
        send_sample(0, 1);
        send_sample(55, 32'hFFFF_FFFF);
        drain();
        load_regs(16'h0123, 16'hFEDC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_sample(32'hFFFF_FFFE, 3);
        send_sample(32'hFFFF_FFFF, 3);
        drain();
        load_regs(16'hFFFF, 16'h0000, 0, 32'hFFFF_FFFF, 3, 0, 32'hFFFF_FFFF, 1);
        send_sample(32'h8000_0000, 1);
        send_sample(32'hFFFF_FFF0, 1);
        drain();

        // Random phases, each with a fresh setting.
        for (phase_idx = 0; phase_idx < 10; phase_idx++)
        begin
            if (phase_idx == 9)
                load_regs(16'($urandom()), 16'($urandom()), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), 16'($urandom()));
            else
                load_regs(16'($urandom()), 16'($urandom()), $urandom_range(0, 50),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30),
                    ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30),
                    $urandom_range(0, 30), $urandom_range(0, 120),
                    16'($urandom_range(0, 6)));
            stall_random = (phase_idx != 3);
            if (phase_idx == 5)
                hold_off_on = 1'b1;      // long receiver hold-off, sender keeps going
            for (n = 0; n < 125; n++)
            begin
                send_sample(pick_time(), pick_step());
                maybe_gap(burst_left);
            end
            drain();
        end

        if (levels.mismatches == 0 && levels.pending_levels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
design/pwsv_pkg.sv
design/pwsv_front.sv
design/pwsv_queue.sv
design/pwsv_back.sv
design/pulse_waveform_source_value_core.sv
design/pwsv_checker.sv
dv/testbench.sv
